@@ design/ipdt_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipdt_pkg - IR pulse-distance transmitter shared definitions
// Payload structs, configuration struct, frame phase codes and helpers.
// ----------------------------------------------------------------------------
package ipdt_pkg;

   typedef struct packed {
      logic        mode;
      logic [31:0] code;
   } req_type;

   typedef struct packed {
      logic ir_out;
      logic busy_res;
      logic frame_done;
      logic start_rejected;
   } rsp_type;

   typedef struct packed {
      logic [7:0] carrier_half_ticks;
      logic [9:0] leader_mark_len;
      logic [9:0] leader_space_len;
      logic [9:0] zero_space_len;
      logic [9:0] one_space_len;
      logic [9:0] bit_mark_len;
      logic [9:0] trail_first_len;
      logic [9:0] trail_last_len;
   } cfg_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_LMARK  = 3'd1,
      PH_LSPACE = 3'd2,
      PH_BSPACE = 3'd3,
      PH_BMARK  = 3'd4,
      PH_TFIRST = 3'd5,
      PH_TSPACE = 3'd6,
      PH_TLAST  = 3'd7
   } phase_type;

   typedef enum logic [2:0] {
      REG_CARRIER_HALF = 3'd0,
      REG_LEADER_MARK  = 3'd1,
      REG_LEADER_SPACE = 3'd2,
      REG_ZERO_SPACE   = 3'd3,
      REG_ONE_SPACE    = 3'd4,
      REG_BIT_MARK     = 3'd5,
      REG_TRAIL_FIRST  = 3'd6,
      REG_TRAIL_LAST   = 3'd7
   } reg_index_type;

   localparam logic [7:0] RST_CARRIER_HALF = 8'd4;
   localparam logic [9:0] RST_LEADER_MARK  = 10'd322;
   localparam logic [9:0] RST_LEADER_SPACE = 10'd479;
   localparam logic [9:0] RST_ZERO_SPACE   = 10'd62;
   localparam logic [9:0] RST_ONE_SPACE    = 10'd199;
   localparam logic [9:0] RST_BIT_MARK     = 10'd21;
   localparam logic [9:0] RST_TRAIL_FIRST  = 10'd5;
   localparam logic [9:0] RST_TRAIL_LAST   = 10'd20;

   function automatic logic is_space(input phase_type p);
      is_space = (p == PH_LSPACE) || (p == PH_BSPACE) || (p == PH_TSPACE);
   endfunction

   function automatic logic [9:0] part_len(input phase_type p, input logic top,
                                           input cfg_type cfg);
      case (p)
         PH_LMARK:  part_len = cfg.leader_mark_len;
         PH_LSPACE: part_len = cfg.leader_space_len;
         PH_BSPACE: part_len = top ? cfg.one_space_len : cfg.zero_space_len;
         PH_BMARK:  part_len = cfg.bit_mark_len;
         PH_TFIRST: part_len = cfg.trail_first_len;
         PH_TSPACE: part_len = cfg.one_space_len;
         PH_TLAST:  part_len = cfg.trail_last_len;
         default:   part_len = 10'd0;
      endcase
   endfunction

endpackage
`default_nettype wire

@@ design/ipdt_csr.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipdt_csr - configuration register file
// Holds the carrier and frame timing registers written over the csr port.
// ----------------------------------------------------------------------------
module ipdt_csr (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           csr_valid,
   output logic                csr_ready,
   input  wire logic [2:0]     csr_index,
   input  wire logic [9:0]     csr_data,
   output ipdt_pkg::cfg_type   cfg
);
   import ipdt_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (reg_index_type'(csr_index))
            REG_CARRIER_HALF: cfg_in.carrier_half_ticks = csr_data[7:0];
            REG_LEADER_MARK:  cfg_in.leader_mark_len    = csr_data;
            REG_LEADER_SPACE: cfg_in.leader_space_len   = csr_data;
            REG_ZERO_SPACE:   cfg_in.zero_space_len     = csr_data;
            REG_ONE_SPACE:    cfg_in.one_space_len      = csr_data;
            REG_BIT_MARK:     cfg_in.bit_mark_len       = csr_data;
            REG_TRAIL_FIRST:  cfg_in.trail_first_len    = csr_data;
            REG_TRAIL_LAST:   cfg_in.trail_last_len     = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.carrier_half_ticks <= RST_CARRIER_HALF;
         cfg_ff.leader_mark_len    <= RST_LEADER_MARK;
         cfg_ff.leader_space_len   <= RST_LEADER_SPACE;
         cfg_ff.zero_space_len     <= RST_ZERO_SPACE;
         cfg_ff.one_space_len      <= RST_ONE_SPACE;
         cfg_ff.bit_mark_len       <= RST_BIT_MARK;
         cfg_ff.trail_first_len    <= RST_TRAIL_FIRST;
         cfg_ff.trail_last_len     <= RST_TRAIL_LAST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ design/ipdt_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ipdt_engine - frame sequencer
// Phase state machine, code shifter and carrier/period counters; one step
// per transfer, result computed combinationally from the current state.
// ----------------------------------------------------------------------------
module ipdt_engine #(
   parameter int CODE_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          step,
   input  ipdt_pkg::req_type  item,
   input  ipdt_pkg::cfg_type  cfg,
   output ipdt_pkg::rsp_type  result
);
   import ipdt_pkg::*;

   localparam int BL_W = $clog2(CODE_BITS + 1);

   phase_type             phase_ff, phase_in;
   logic [CODE_BITS-1:0]  sw_ff, sw_in, sw_shift;
   logic [BL_W-1:0]       bl_ff, bl_in, bl_dec;
   logic [9:0]            pc_ff, pc_in, pc_next;
   logic [7:0]            ht_ff, ht_in, ht_next;
   logic                  lvl_ff, lvl_in;
   logic                  top_cur, top_shift;
   logic [9:0]            cur_len;

   assign sw_shift  = sw_ff << 1;
   assign bl_dec    = bl_ff - 1'b1;
   assign top_cur   = sw_ff[CODE_BITS-1];
   assign top_shift = sw_shift[CODE_BITS-1];
   assign ht_next   = ht_ff + 8'd1;
   assign pc_next   = pc_ff + 10'd1;
   assign cur_len   = part_len(phase_ff, top_cur, cfg);

   always_comb begin
      phase_in = phase_ff;
      sw_in    = sw_ff;
      bl_in    = bl_ff;
      pc_in    = pc_ff;
      ht_in    = ht_ff;
      lvl_in   = lvl_ff;
      result   = '0;
      if (step) begin
         if (item.mode) begin
            if (phase_ff != PH_IDLE) begin
               result.start_rejected = 1'b1;
               result.ir_out         = !is_space(phase_ff) && lvl_ff;
            end else begin
               sw_in    = item.code[CODE_BITS-1:0];
               bl_in    = BL_W'(CODE_BITS);
               pc_in    = '0;
               ht_in    = '0;
               lvl_in   = 1'b1;
               phase_in = PH_LMARK;
            end
         end else if (phase_ff != PH_IDLE) begin
            result.ir_out = !is_space(phase_ff) && lvl_ff;
            ht_in = ht_next;
            if (ht_next >= cfg.carrier_half_ticks) begin
               ht_in = '0;
               if (lvl_ff) begin
                  lvl_in = 1'b0;
               end else begin
                  lvl_in = 1'b1;
                  pc_in  = pc_next;
                  if (pc_next >= cur_len) begin
                     pc_in  = '0;
                     ht_in  = '0;
                     lvl_in = 1'b1;
                     case (phase_ff)
                        PH_LMARK: begin
                           if (cfg.leader_space_len != 10'd0) begin
                              phase_in = PH_LSPACE;
                           end else if (part_len(PH_BSPACE, top_cur, cfg) != 10'd0) begin
                              phase_in = PH_BSPACE;
                           end else begin
                              phase_in = PH_BMARK;
                           end
                        end
                        PH_LSPACE: begin
                           if (part_len(PH_BSPACE, top_cur, cfg) != 10'd0) begin
                              phase_in = PH_BSPACE;
                           end else begin
                              phase_in = PH_BMARK;
                           end
                        end
                        PH_BSPACE: phase_in = PH_BMARK;
                        PH_BMARK: begin
                           sw_in = sw_shift;
                           bl_in = bl_dec;
                           if (bl_dec == '0) begin
                              phase_in = PH_TFIRST;
                           end else if (part_len(PH_BSPACE, top_shift, cfg) != 10'd0) begin
                              phase_in = PH_BSPACE;
                           end else begin
                              phase_in = PH_BMARK;
                           end
                        end
                        PH_TFIRST: begin
                           if (cfg.one_space_len != 10'd0) begin
                              phase_in = PH_TSPACE;
                           end else begin
                              phase_in = PH_TLAST;
                           end
                        end
                        PH_TSPACE: phase_in = PH_TLAST;
                        default: begin
                           phase_in          = PH_IDLE;
                           lvl_in            = 1'b0;
                           result.frame_done = 1'b1;
                        end
                     endcase
                  end
               end
            end
         end
         result.busy_res = (phase_in != PH_IDLE);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         sw_ff    <= '0;
         bl_ff    <= '0;
         pc_ff    <= '0;
         ht_ff    <= '0;
         lvl_ff   <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         sw_ff    <= sw_in;
         bl_ff    <= bl_in;
         pc_ff    <= pc_in;
         ht_ff    <= ht_in;
         lvl_ff   <= lvl_in;
      end
   end

`ifndef ASSERT_OFF
   idle_level_low: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == PH_IDLE) |-> !lvl_ff)
      else $error("carrier level high while idle");

   done_goes_idle: assert property (@(posedge clock) disable iff (reset)
      (step && result.frame_done) |=> (phase_ff == PH_IDLE))
      else $error("frame_done without return to idle");

   bits_left_bound: assert property (@(posedge clock) disable iff (reset)
      (phase_ff != PH_IDLE) |-> (bl_ff <= BL_W'(CODE_BITS)))
      else $error("bit counter out of range");
`endif

endmodule
`default_nettype wire

@@ design/ir_pulse_distance_transmitter_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// ir_pulse_distance_transmitter_core - NEC-style IR frame transmitter
// Input register, frame sequencer and result register with a csr port.
// ----------------------------------------------------------------------------
// Each request transfer is either a start (load a code, begin a frame) or one
// tick of the carrier timebase, and yields exactly one response. Throughput is
// one item per clock while rsp_stall is low: the item is held in the input
// register, the frame sequencer updates its state as the item leaves it, and
// the result is registered in the output register that drives rsp_valid.
// The two registers let a new request be taken while a response is stalled.
// Configuration registers are written through csr_* (csr_ready is always
// high) and should be changed only while no items are in flight.
module ir_pulse_distance_transmitter_core #(
   parameter int CODE_BITS = 32
) (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_stall,
   input  ipdt_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire logic          rsp_stall,
   output ipdt_pkg::rsp_type  rsp_data,
   input  wire logic          csr_valid,
   output logic               csr_ready,
   input  wire logic [2:0]    csr_index,
   input  wire logic [9:0]    csr_data
);
   import ipdt_pkg::*;

   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_data_ff;
   logic    advance;
   cfg_type cfg;
   rsp_type result;

   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   assign in_valid_in  = (req_valid && !req_stall) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && rsp_stall);

   ipdt_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   ipdt_engine #(
      .CODE_BITS (CODE_BITS)
   ) u_engine (
      .clock  (clock),
      .reset  (reset),
      .step   (advance),
      .item   (in_data_ff),
      .cfg    (cfg),
      .result (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         out_data_ff <= result;
      end
   end

`ifndef ASSERT_OFF
   done_not_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.frame_done) |-> !rsp_data.busy_res)
      else $error("frame_done reported while busy");

   reject_is_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.start_rejected) |-> rsp_data.busy_res)
      else $error("start rejected while idle");

   idle_dark: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.busy_res && !rsp_data.frame_done) |-> !rsp_data.ir_out)
      else $error("emitter driven while idle");

   stall_holds_input: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_data_ff))
      else $error("input register lost a held item");
`endif

endmodule
`default_nettype wire
